@@ rtl/core/keyed_autokey_letter_cipher_assert.svh @@
// ----------------------------------------------------------------------------
// keyed autokey letter cipher assertion macros
// concurrent assertion wrappers, empty when built for synthesis
// ----------------------------------------------------------------------------
`ifndef KEYED_AUTOKEY_LETTER_CIPHER_ASSERT_SVH
`define KEYED_AUTOKEY_LETTER_CIPHER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define KALC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kalc assertion failed");
// next-cycle implication
`define KALC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kalc assertion failed");
`else
`define KALC_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define KALC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/core/kalc_pkg.sv @@
// ----------------------------------------------------------------------------
// kalc_pkg
// shared types, codes and constants of the keyed autokey letter cipher
// ----------------------------------------------------------------------------
package kalc_pkg;

   localparam int NumLetters = 26;
   localparam int QueueDepth = 2;

   localparam logic [7:0] UpperA = 8'h41;
   localparam logic [7:0] UpperZ = 8'h5a;
   localparam logic [7:0] LowerA = 8'h61;
   localparam logic [7:0] LowerZ = 8'h7a;

   // request function codes
   localparam logic [1:0] FUNC_ENCRYPT = 2'd0;
   localparam logic [1:0] FUNC_DECRYPT = 2'd1;
   localparam logic [1:0] FUNC_KEY     = 2'd2;

   // response status codes
   localparam logic [1:0] STATUS_TEXT = 2'd0;
   localparam logic [1:0] STATUS_GOOD = 2'd1;
   localparam logic [1:0] STATUS_BAD  = 2'd2;

   typedef enum logic [1:0] {
      KIND_ENCRYPT,
      KIND_DECRYPT,
      KIND_KEY
   } kind_type;

   // classified transaction handed from front to back
   typedef struct packed {
      kind_type    kind;
      logic        is_letter;
      logic [4:0]  idx;
      logic        lower;
      logic [7:0]  char_val;
      logic        line_start;
      logic        key_last;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ rtl/core/kalc_front.sv @@
// ----------------------------------------------------------------------------
// kalc_front
// accepts request transactions, classifies the character and drops unused codes
// ----------------------------------------------------------------------------
module kalc_front (
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_func,
   input  logic [7:0]                 req_byte_in,
   input  logic                       req_line_start,
   input  logic                       req_key_last,
   input  kalc_pkg::queue_status_type q_status,
   output logic                       push,
   output kalc_pkg::item_type         push_item
);

   logic is_upper;
   logic is_lower;

   assign req_ready = !q_status.full;
   assign is_upper  = req_byte_in inside {[kalc_pkg::UpperA:kalc_pkg::UpperZ]};
   assign is_lower  = req_byte_in inside {[kalc_pkg::LowerA:kalc_pkg::LowerZ]};

   always_comb begin
      push_item.is_letter  = is_upper || is_lower;
      push_item.lower      = is_lower;
      push_item.idx        = is_lower ? 5'(req_byte_in - kalc_pkg::LowerA)
                                      : 5'(req_byte_in - kalc_pkg::UpperA);
      push_item.char_val   = req_byte_in;
      push_item.line_start = req_line_start;
      push_item.key_last   = req_key_last;
      push_item.kind       = kalc_pkg::KIND_ENCRYPT;
      push                 = 1'b0;
      case (req_func)
         kalc_pkg::FUNC_ENCRYPT: begin
            push_item.kind = kalc_pkg::KIND_ENCRYPT;
            push           = req_valid && req_ready;
         end
         kalc_pkg::FUNC_DECRYPT: begin
            push_item.kind = kalc_pkg::KIND_DECRYPT;
            push           = req_valid && req_ready;
         end
         kalc_pkg::FUNC_KEY: begin
            push_item.kind = kalc_pkg::KIND_KEY;
            push           = req_valid && req_ready;
         end
         default: begin
            // unused code: taken and discarded
            push = 1'b0;
         end
      endcase
   end

endmodule

@@ rtl/core/kalc_queue.sv @@
// ----------------------------------------------------------------------------
// kalc_queue
// short queue of classified transactions between front and back
// ----------------------------------------------------------------------------
module kalc_queue #(
   parameter int Depth = kalc_pkg::QueueDepth
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  kalc_pkg::item_type         push_item,
   input  logic                       pop,
   output kalc_pkg::item_type         head_item,
   output kalc_pkg::queue_status_type q_status
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   kalc_pkg::item_type slot_ff [Depth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff, count_in;

   assign head_item      = slot_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == FullCnt);
   assign q_status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/core/kalc_back.sv @@
// ----------------------------------------------------------------------------
// kalc_back
// cipher execution, key collection and alphabet install, response register
// ----------------------------------------------------------------------------
module kalc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  kalc_pkg::item_type head_item,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_byte_out,
   output logic [1:0]         rsp_status
);

   localparam int N = kalc_pkg::NumLetters;
   localparam logic [4:0] NLet5 = 5'(kalc_pkg::NumLetters);
   localparam logic [5:0] NLet6 = 6'(kalc_pkg::NumLetters);

   // installed alphabet and its inverse
   logic [4:0] let_ff [N];
   logic [4:0] let_in [N];
   logic [4:0] pos_ff [N];
   logic [4:0] pos_in [N];
   // staged alphabet and its inverse, valid only once fully written
   logic [4:0] stg_let_ff [N];
   logic [4:0] stg_let_in [N];
   logic [4:0] stg_pos_ff [N];
   logic [4:0] stg_pos_in [N];

   logic [N-1:0] seen_ff, seen_in;
   logic [4:0]   cnt_ff, cnt_in;
   logic         err_ff, err_in;
   logic         prev_let_ff, prev_let_in;
   logic [4:0]   prev_pos_ff, prev_pos_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   rsp_byte_ff, rsp_byte_in;
   logic [1:0]   rsp_status_ff, rsp_status_in;

   logic out_free;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign pop          = head_valid && out_free;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_byte_out = rsp_byte_ff;
   assign rsp_status   = rsp_status_ff;

   always_comb begin
      logic [N-1:0] seen_w;
      logic [4:0]   cnt_w;
      logic         err_w;
      logic         produce;
      logic [4:0]   p;
      logic [4:0]   c;
      logic [4:0]   k;
      logic [5:0]   s;

      let_in      = let_ff;
      pos_in      = pos_ff;
      stg_let_in  = stg_let_ff;
      stg_pos_in  = stg_pos_ff;
      seen_in     = seen_ff;
      cnt_in      = cnt_ff;
      err_in      = err_ff;
      prev_let_in = prev_let_ff;
      prev_pos_in = prev_pos_ff;
      produce     = 1'b0;
      rsp_byte_in   = rsp_byte_ff;
      rsp_status_in = rsp_status_ff;

      seen_w = head_item.line_start ? '0 : seen_ff;
      cnt_w  = head_item.line_start ? '0 : cnt_ff;
      err_w  = head_item.line_start ? 1'b0 : err_ff;

      p = (!head_item.line_start && prev_let_ff) ? prev_pos_ff : pos_ff[0];
      c = pos_ff[head_item.idx];
      s = {1'b0, c} + {1'b0, p};
      k = '0;

      if (pop) begin
         case (head_item.kind)
            kalc_pkg::KIND_KEY: begin
               prev_let_in = 1'b0;
               if (head_item.is_letter && !err_w) begin
                  if (seen_w[head_item.idx]) begin
                     err_w = 1'b1;
                  end else if (cnt_w < NLet5) begin
                     seen_w[head_item.idx]     = 1'b1;
                     stg_let_in[cnt_w]         = head_item.idx;
                     stg_pos_in[head_item.idx] = cnt_w;
                     cnt_w                     = cnt_w + 1'b1;
                  end else begin
                     err_w = 1'b1;
                  end
               end
               if (head_item.key_last) begin
                  produce     = 1'b1;
                  rsp_byte_in = '0;
                  if (!err_w && cnt_w == NLet5) begin
                     let_in        = stg_let_in;
                     pos_in        = stg_pos_in;
                     rsp_status_in = kalc_pkg::STATUS_GOOD;
                  end else begin
                     for (int i = 0; i < N; i++) begin
                        let_in[i] = 5'(i);
                        pos_in[i] = 5'(i);
                     end
                     rsp_status_in = kalc_pkg::STATUS_BAD;
                  end
                  seen_in = '0;
                  cnt_in  = '0;
                  err_in  = 1'b0;
               end else begin
                  seen_in = seen_w;
                  cnt_in  = cnt_w;
                  err_in  = err_w;
               end
            end
            kalc_pkg::KIND_ENCRYPT, kalc_pkg::KIND_DECRYPT: begin
               produce       = 1'b1;
               rsp_status_in = kalc_pkg::STATUS_TEXT;
               if (!head_item.is_letter) begin
                  rsp_byte_in = head_item.char_val;
                  prev_let_in = 1'b0;
               end else begin
                  if (head_item.kind == kalc_pkg::KIND_ENCRYPT) begin
                     k           = (c >= p) ? (c - p) : 5'({1'b0, c} + NLet6 - {1'b0, p});
                     prev_pos_in = c;
                  end else begin
                     k           = (s >= NLet6) ? 5'(s - NLet6) : s[4:0];
                     prev_pos_in = k;
                  end
                  prev_let_in = 1'b1;
                  rsp_byte_in = {3'b000, let_ff[k]}
                              + (head_item.lower ? kalc_pkg::LowerA : kalc_pkg::UpperA);
               end
            end
            default: begin
               produce = 1'b0;
            end
         endcase
      end

      if (pop && produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            let_ff[i] <= 5'(i);
            pos_ff[i] <= 5'(i);
         end
         seen_ff      <= '0;
         cnt_ff       <= '0;
         err_ff       <= 1'b0;
         prev_let_ff  <= 1'b0;
         prev_pos_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         let_ff       <= let_in;
         pos_ff       <= pos_in;
         seen_ff      <= seen_in;
         cnt_ff       <= cnt_in;
         err_ff       <= err_in;
         prev_let_ff  <= prev_let_in;
         prev_pos_ff  <= prev_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // staged alphabet and response payload need no reset
   always_ff @(posedge clock) begin
      stg_let_ff    <= stg_let_in;
      stg_pos_ff    <= stg_pos_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

@@ rtl/core/keyed_autokey_letter_cipher.sv @@
// ----------------------------------------------------------------------------
// keyed_autokey_letter_cipher
// differential autokey letter cipher over a keyed alphabet, streaming top level
// ----------------------------------------------------------------------------
// usage
//   request channel (req_): one character transaction per handshake; func
//   selects encrypt, decrypt or key load, line_start opens a text line or a
//   key, key_last closes a key load. the unused func code is taken and dropped
//   response channel (rsp_): one transaction per text character (status text)
//   and one per closing key byte (status good or bad, byte_out zero); key
//   bytes that do not close a load give nothing
//   path: an accepted transaction is written into the queue, then taken by
//   the back end into the registered response
//   throughput: one transaction per cycle while the receiver takes responses
//   (inverse table look-up, mod-26 add and alphabet look-up are combinational)
//   reset: identity alphabet, key collection empty, no previous letter; no
//   clearing pass, the block is ready in the first cycle after reset
//   receiver stall: the response register holds, the back end halts, the
//   queue fills and req_ready drops once it is full
// ----------------------------------------------------------------------------
`include "keyed_autokey_letter_cipher_assert.svh"

module keyed_autokey_letter_cipher #(
   parameter int QueueDepth = kalc_pkg::QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_func,
   input  logic [7:0] req_byte_in,
   input  logic       req_line_start,
   input  logic       req_key_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_byte_out,
   output logic [1:0] rsp_status
);

   // front to queue
   logic                       push;
   kalc_pkg::item_type         push_item;
   // queue to back
   logic                       pop;
   kalc_pkg::item_type         head_item;
   kalc_pkg::queue_status_type q_status;

   // classification of incoming characters
   kalc_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_byte_in    (req_byte_in),
      .req_line_start (req_line_start),
      .req_key_last   (req_key_last),
      .q_status       (q_status),
      .push           (push),
      .push_item      (push_item)
   );

   // decoupling queue, lets each side stall on its own
   kalc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   // cipher state, key install and response register
   kalc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (!q_status.empty),
      .head_item    (head_item),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_byte_out (rsp_byte_out),
      .rsp_status   (rsp_status)
   );

   // the back end never takes from an empty queue
   `KALC_ASSERT_IMPLIES(a_pop_not_empty, clock, reset, pop, !q_status.empty)
   // key status transactions carry a zero character
   `KALC_ASSERT_IMPLIES(a_status_zero_byte, clock, reset,
      rsp_valid && rsp_status != kalc_pkg::STATUS_TEXT, rsp_byte_out == 8'h00)
   // nothing queued and nothing arriving means no response next cycle
   `KALC_ASSERT_NEXT(a_no_spurious_rsp, clock, reset,
      !rsp_valid && q_status.empty && !push, !rsp_valid)

endmodule
